// File: design/rcddm_pkg.sv
// shared types, constants and helpers for the rc differential drive mixer
package rcddm_pkg;

    localparam int CH_W     = 11;   // rc channel width
    localparam int SPEED_W  = 16;   // wheel and target speed width
    localparam int NUM_W    = 12;   // signed stick offset width
    localparam int SUM_W    = 20;   // mix sum width before saturation
    localparam int TRACK_W  = 12;
    localparam int TICKS_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_TICKS = 2'd1;

    localparam logic [TRACK_W-1:0] TRACK_RESET    = 12'd512;
    localparam logic [TICKS_W-1:0] FAILSAFE_RESET = 4'd10;

    // mode channel bands
    localparam logic [CH_W-1:0] MODE_STOP_LIM = 11'd600;
    localparam logic [CH_W-1:0] MODE_RC_LIM   = 11'd1400;
    // pitch channel bands
    localparam logic [CH_W-1:0] PITCH_FWD_LIM = 11'd1400;
    localparam logic [CH_W-1:0] PITCH_BWD_LIM = 11'd600;
    // roll dead zone
    localparam logic [CH_W-1:0] ROLL_LOW_LIM  = 11'd700;
    localparam logic [CH_W-1:0] ROLL_HIGH_LIM = 11'd1300;
    // stick centers
    localparam logic signed [NUM_W-1:0] THR_CENTER  = 12'sd2000;
    localparam logic signed [NUM_W-1:0] ROLL_CENTER = 12'sd1000;

    // divide by 800 = 32 * 25, by 400 = 16 * 25: power of two part is a shift
    localparam int SCALE_ODD_DIV = 25;
    localparam int LIN_DIV_LOG2  = 5;
    localparam int ANG_DIV_LOG2  = 4;

    localparam int MIX_SHIFT = 11;  // track * angular / 2048

    typedef enum logic [1:0] {
        MODE_STOP   = 2'd0,
        MODE_UPLINK = 2'd1,
        MODE_RC     = 2'd2,
        MODE_HOLD   = 2'd3
    } t_drive_mode;

    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SUM_W-1:0] v);
        logic signed [SPEED_W-1:0] res;
        if (v > SUM_W'(32767)) begin
            res = 16'sh7fff;
        end else if (v < -SUM_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: design/rcddm_scale.sv
// stick offset to speed scaling: (num << shift) / 25, toward zero, saturated
module rcddm_scale #(
    parameter int SHIFT = 5
) (
    input  logic signed [rcddm_pkg::NUM_W-1:0]   i_num,
    output logic signed [rcddm_pkg::SPEED_W-1:0] o_speed
);

    localparam int MAG_W = rcddm_pkg::NUM_W;
    localparam int XW    = MAG_W + SHIFT;
    localparam int K     = XW + 5;                 // reciprocal precision
    localparam int MW    = K - 4;                  // 2^K / 25 < 2^(K-4)
    localparam int PW    = XW + MW;
    localparam int QW    = PW - K;
    localparam longint unsigned RECIP =
        ((64'd1 << K) + 64'(rcddm_pkg::SCALE_ODD_DIV) - 64'd1) /
        64'(rcddm_pkg::SCALE_ODD_DIV);

    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [XW-1:0]    x;
    logic [PW-1:0]    prod;
    logic [QW-1:0]    q;
    logic [31:0]      q32;

    always_comb begin
        neg  = i_num[rcddm_pkg::NUM_W-1];
        mag  = neg ? MAG_W'(-i_num) : MAG_W'(i_num);
        x    = XW'(mag) << SHIFT;
        // exact floor(x / 25) by reciprocal multiply
        prod = PW'(x) * PW'(MW'(RECIP));
        q    = prod[PW-1:K];
        q32  = 32'(q);
        if (neg) begin
            if (q32 >= 32'd32768) begin
                o_speed = 16'sh8000;
            end else begin
                o_speed = -$signed(q32[rcddm_pkg::SPEED_W-1:0]);
            end
        end else begin
            if (q32 > 32'd32767) begin
                o_speed = 16'sh7fff;
            end else begin
                o_speed = $signed(q32[rcddm_pkg::SPEED_W-1:0]);
            end
        end
    end

endmodule

// File: design/rc_differential_drive_mixer_core.sv
// rc differential drive mixer: mode select, stick scaling, failsafe hold and wheel mix
// a word passes the input, target and wheel speed registers in turn
// throughput: one word per cycle unless the output stalls, three register stages
// the target stage holds the failsafe counter and held targets, so each word sees
// the state left by the word before it with no bubble
// reset (i_rst_n low, synchronous): pipeline empties, counter and held targets clear,
// track_width returns to 512 and failsafe_ticks to 10
module rc_differential_drive_mixer_core #(
    parameter int SPEED_FRAC_BITS = 10
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // config write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [rcddm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rcddm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input word
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_frame_valid,
    input  logic [rcddm_pkg::CH_W-1:0]              i_roll_channel,
    input  logic [rcddm_pkg::CH_W-1:0]              i_throttle_channel,
    input  logic [rcddm_pkg::CH_W-1:0]              i_pitch_channel,
    input  logic [rcddm_pkg::CH_W-1:0]              i_mode_channel,
    input  logic signed [rcddm_pkg::SPEED_W-1:0]    i_uplink_linear,
    input  logic signed [rcddm_pkg::SPEED_W-1:0]    i_uplink_angular,
    // result word
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [rcddm_pkg::SPEED_W-1:0]    o_left_speed,
    output logic signed [rcddm_pkg::SPEED_W-1:0]    o_right_speed,
    output logic signed [rcddm_pkg::SPEED_W-1:0]    o_target_linear,
    output logic signed [rcddm_pkg::SPEED_W-1:0]    o_target_angular,
    output logic [1:0]                              o_drive_mode
);

    localparam int LIN_SHIFT = SPEED_FRAC_BITS - rcddm_pkg::LIN_DIV_LOG2;
    localparam int ANG_SHIFT = SPEED_FRAC_BITS - rcddm_pkg::ANG_DIV_LOG2;
    localparam int SW  = rcddm_pkg::SPEED_W;
    localparam int PRW = SW + rcddm_pkg::TRACK_W + 1;   // signed mix product width

    // config registers
    logic [rcddm_pkg::TRACK_W-1:0] r_track;
    logic [rcddm_pkg::TICKS_W-1:0] r_failsafe;

    // failsafe state
    logic [rcddm_pkg::TICKS_W-1:0] r_missed, n_missed;
    logic signed [SW-1:0]          r_held_lin, r_held_ang;

    // input stage
    logic                          r_in_valid;
    logic                          r_in_frame;
    logic [rcddm_pkg::CH_W-1:0]    r_in_roll, r_in_thr, r_in_pitch, r_in_mode;
    logic signed [SW-1:0]          r_in_up_lin, r_in_up_ang;

    // target stage
    logic                          r_tgt_valid;
    logic signed [SW-1:0]          r_tgt_lin, r_tgt_ang;
    rcddm_pkg::t_drive_mode        r_tgt_mode;
    logic signed [SW-1:0]          n_tgt_lin, n_tgt_ang;
    rcddm_pkg::t_drive_mode        n_tgt_mode;

    // output stage
    logic                          r_out_valid;
    logic signed [SW-1:0]          r_out_left, r_out_right, r_out_lin, r_out_ang;
    rcddm_pkg::t_drive_mode        r_out_mode;

    // flow control
    logic out_free, tgt_free, in_free;
    logic in_load, tgt_load, out_load;

    // stick scaling
    logic signed [rcddm_pkg::NUM_W-1:0] lin_num, ang_num;
    logic signed [SW-1:0]               lin_scaled, ang_scaled;
    logic                               pitch_fwd, pitch_dead, roll_active;
    logic signed [rcddm_pkg::NUM_W-1:0] thr_s, roll_s;

    // mix
    logic signed [PRW-1:0]                 mix_ang, mix_track, mix_prod, mix_bias, mix_half_full;
    logic signed [rcddm_pkg::SUM_W-1:0]    mix_half, mix_lin, sum_left, sum_right;

    // each stage moves when the next one is empty or emptying
    assign out_free   = !r_out_valid || !i_out_stall;
    assign tgt_free   = !r_tgt_valid || out_free;
    assign in_free    = !r_in_valid || tgt_free;
    assign o_in_stall = !in_free;
    assign in_load    = i_in_valid && in_free;
    assign tgt_load   = r_in_valid && tgt_free;
    assign out_load   = r_tgt_valid && out_free;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track    <= rcddm_pkg::TRACK_RESET;
            r_failsafe <= rcddm_pkg::FAILSAFE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rcddm_pkg::REG_TRACK_WIDTH:    r_track    <= i_cfg_data;
                rcddm_pkg::REG_FAILSAFE_TICKS: r_failsafe <= i_cfg_data[rcddm_pkg::TICKS_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_frame  <= i_frame_valid;
            r_in_roll   <= i_roll_channel;
            r_in_thr    <= i_throttle_channel;
            r_in_pitch  <= i_pitch_channel;
            r_in_mode   <= i_mode_channel;
            r_in_up_lin <= i_uplink_linear;
            r_in_up_ang <= i_uplink_angular;
        end
    end

    // stick offsets: forward is center minus throttle, backward the negation
    always_comb begin
        thr_s       = $signed({1'b0, r_in_thr});
        roll_s      = $signed({1'b0, r_in_roll});
        pitch_fwd   = r_in_pitch > rcddm_pkg::PITCH_FWD_LIM;
        pitch_dead  = r_in_pitch > rcddm_pkg::PITCH_BWD_LIM;
        roll_active = (r_in_roll > rcddm_pkg::ROLL_HIGH_LIM) ||
                      (r_in_roll < rcddm_pkg::ROLL_LOW_LIM);
        lin_num     = pitch_fwd ? (rcddm_pkg::THR_CENTER - thr_s)
                                : (thr_s - rcddm_pkg::THR_CENTER);
        ang_num     = rcddm_pkg::ROLL_CENTER - roll_s;
    end

    rcddm_scale #(.SHIFT(LIN_SHIFT)) u_scale_lin (
        .i_num   (lin_num),
        .o_speed (lin_scaled)
    );

    rcddm_scale #(.SHIFT(ANG_SHIFT)) u_scale_ang (
        .i_num   (ang_num),
        .o_speed (ang_scaled)
    );

    // mode select and failsafe
    always_comb begin
        n_missed   = r_missed;
        n_tgt_lin  = r_held_lin;
        n_tgt_ang  = r_held_ang;
        n_tgt_mode = rcddm_pkg::MODE_HOLD;
        if (!r_in_frame) begin
            if (r_missed < r_failsafe) begin
                // lost frame within tolerance: repeat last targets
                n_missed   = r_missed + 4'd1;
                n_tgt_lin  = r_held_lin;
                n_tgt_ang  = r_held_ang;
                n_tgt_mode = rcddm_pkg::MODE_HOLD;
            end else begin
                // tolerance used up: uplink takes over, counter parks
                n_tgt_lin  = r_in_up_lin;
                n_tgt_ang  = r_in_up_ang;
                n_tgt_mode = rcddm_pkg::MODE_UPLINK;
            end
        end else begin
            n_missed = '0;
            priority if (r_in_mode < rcddm_pkg::MODE_STOP_LIM) begin
                n_tgt_lin  = '0;
                n_tgt_ang  = '0;
                n_tgt_mode = rcddm_pkg::MODE_STOP;
            end else if (r_in_mode < rcddm_pkg::MODE_RC_LIM) begin
                n_tgt_lin  = r_in_up_lin;
                n_tgt_ang  = r_in_up_ang;
                n_tgt_mode = rcddm_pkg::MODE_UPLINK;
            end else begin
                n_tgt_mode = rcddm_pkg::MODE_RC;
                n_tgt_lin  = (pitch_fwd || !pitch_dead) ? lin_scaled : '0;
                n_tgt_ang  = roll_active ? ang_scaled : '0;
            end
        end
    end

    // target stage, also the failsafe state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_valid <= 1'b0;
            r_missed    <= '0;
            r_held_lin  <= '0;
            r_held_ang  <= '0;
        end else begin
            if (tgt_free) begin
                r_tgt_valid <= r_in_valid;
            end
            if (tgt_load) begin
                r_missed   <= n_missed;
                r_held_lin <= n_tgt_lin;
                r_held_ang <= n_tgt_ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tgt_load) begin
            r_tgt_lin  <= n_tgt_lin;
            r_tgt_ang  <= n_tgt_ang;
            r_tgt_mode <= n_tgt_mode;
        end
    end

    // mix: half = angular * track / 2048, rounded toward zero
    always_comb begin
        mix_ang       = PRW'(r_tgt_ang);
        mix_track     = PRW'($signed({1'b0, r_track}));
        mix_prod      = mix_ang * mix_track;
        mix_bias      = mix_prod[PRW-1] ? PRW'((1 << rcddm_pkg::MIX_SHIFT) - 1) : '0;
        mix_half_full = (mix_prod + mix_bias) >>> rcddm_pkg::MIX_SHIFT;
        mix_half      = rcddm_pkg::SUM_W'(mix_half_full);
        mix_lin       = rcddm_pkg::SUM_W'(r_tgt_lin);
        sum_left      = mix_lin - mix_half;
        sum_right     = mix_lin + mix_half;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_tgt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_left  <= rcddm_pkg::sat_speed(sum_left);
            r_out_right <= rcddm_pkg::sat_speed(sum_right);
            r_out_lin   <= r_tgt_lin;
            r_out_ang   <= r_tgt_ang;
            r_out_mode  <= r_tgt_mode;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_speed     = r_out_left;
    assign o_right_speed    = r_out_right;
    assign o_target_linear  = r_out_lin;
    assign o_target_angular = r_out_ang;
    assign o_drive_mode     = 2'(r_out_mode);

    // missed-frame counter only clears or steps by one
    a_missed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_missed != $past(r_missed)) |->
        (r_missed == '0 || r_missed == $past(r_missed) + 4'd1))
        else $error("missed frame counter jumped");

    // held targets track the targets just passed on
    a_held_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tgt_load |=> (r_held_lin == r_tgt_lin && r_held_ang == r_tgt_ang))
        else $error("held targets out of step with target stage");

    // hold mode repeats the targets held before
    a_hold_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tgt_load |=> (r_tgt_mode != rcddm_pkg::MODE_HOLD ||
                      (r_tgt_lin == $past(r_held_lin) && r_tgt_ang == $past(r_held_ang))))
        else $error("hold mode changed the targets");

    // stop mode drives nothing
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_mode == 2'(rcddm_pkg::MODE_STOP)) |->
        (o_left_speed == '0 && o_right_speed == '0 &&
         o_target_linear == '0 && o_target_angular == '0))
        else $error("stop mode with nonzero speed");

    // stall toward the source only with a word parked in every stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_tgt_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

endmodule

// File: sim/rc_differential_drive_mixer_core_tb.sv
// testbench for the rc differential drive mixer core: predicted wheel commands checked per word
`timescale 1ns / 100ps

module rc_differential_drive_mixer_core_tb;

    localparam int FRAC_BITS       = 10;
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int HOLD_OFF_CYCLES = 200;   // long receiver hold-off for the fill test
    localparam int SETTLE_CYCLES   = 6;     // extra wait after the last booked word has come back
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_WORDS     = 125;

    // config indexes with no register behind them
    localparam logic [rcddm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [rcddm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // one control tick as the sender offers it
    typedef struct packed {
        logic                                 frame;
        logic [rcddm_pkg::CH_W-1:0]           roll;
        logic [rcddm_pkg::CH_W-1:0]           thr;
        logic [rcddm_pkg::CH_W-1:0]           pitch;
        logic [rcddm_pkg::CH_W-1:0]           mode_ch;
        logic signed [rcddm_pkg::SPEED_W-1:0] up_lin;
        logic signed [rcddm_pkg::SPEED_W-1:0] up_ang;
    } t_rc_tick;

    // one wheel command word as the block returns it
    typedef struct packed {
        logic signed [rcddm_pkg::SPEED_W-1:0] left_spd;
        logic signed [rcddm_pkg::SPEED_W-1:0] right_spd;
        logic signed [rcddm_pkg::SPEED_W-1:0] lin;
        logic signed [rcddm_pkg::SPEED_W-1:0] ang;
        rcddm_pkg::t_drive_mode               mode;
    } t_wheel_cmd;

    logic                                 i_clk;
    logic                                 i_rst_n            = 1'b0;
    logic                                 i_cfg_valid        = 1'b0;
    logic                                 o_cfg_ready;
    logic [rcddm_pkg::CFG_IDX_W-1:0]      i_cfg_index        = '0;
    logic [rcddm_pkg::CFG_DATA_W-1:0]     i_cfg_data         = '0;
    logic                                 i_in_valid         = 1'b0;
    logic                                 o_in_stall;
    logic                                 i_frame_valid      = 1'b0;
    logic [rcddm_pkg::CH_W-1:0]           i_roll_channel     = '0;
    logic [rcddm_pkg::CH_W-1:0]           i_throttle_channel = '0;
    logic [rcddm_pkg::CH_W-1:0]           i_pitch_channel    = '0;
    logic [rcddm_pkg::CH_W-1:0]           i_mode_channel     = '0;
    logic signed [rcddm_pkg::SPEED_W-1:0] i_uplink_linear    = '0;
    logic signed [rcddm_pkg::SPEED_W-1:0] i_uplink_angular   = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall        = 1'b0;
    logic signed [rcddm_pkg::SPEED_W-1:0] o_left_speed;
    logic signed [rcddm_pkg::SPEED_W-1:0] o_right_speed;
    logic signed [rcddm_pkg::SPEED_W-1:0] o_target_linear;
    logic signed [rcddm_pkg::SPEED_W-1:0] o_target_angular;
    logic [1:0]                           o_drive_mode;

    rc_differential_drive_mixer_core #(
        .SPEED_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_frame_valid      (i_frame_valid),
        .i_roll_channel     (i_roll_channel),
        .i_throttle_channel (i_throttle_channel),
        .i_pitch_channel    (i_pitch_channel),
        .i_mode_channel     (i_mode_channel),
        .i_uplink_linear    (i_uplink_linear),
        .i_uplink_angular   (i_uplink_angular),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_left_speed       (o_left_speed),
        .o_right_speed      (o_right_speed),
        .o_target_linear    (o_target_linear),
        .o_target_angular   (o_target_angular),
        .o_drive_mode       (o_drive_mode)
    );

    // mixer state as the testbench sees it
    logic [rcddm_pkg::TRACK_W-1:0]        cur_track;
    logic [rcddm_pkg::TICKS_W-1:0]        cur_failsafe;
    logic [rcddm_pkg::TICKS_W-1:0]        missed_cnt;
    logic signed [rcddm_pkg::SPEED_W-1:0] last_lin;
    logic signed [rcddm_pkg::SPEED_W-1:0] last_ang;

    t_wheel_cmd cmd_q[$];       // wheel commands still owed by the block
    int         fail_count   = 0;
    bit         no_idle      = 1'b0;  // both sides run flat out while set
    bit         hold_off_req = 1'b0;  // asks the receiver for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [rcddm_pkg::SPEED_W-1:0] clamp_speed(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return rcddm_pkg::SPEED_W'(v);
    endfunction

    // (num << frac) / den, truncated toward zero
    function automatic logic signed [rcddm_pkg::SPEED_W-1:0] stick_speed(input longint num,
                                                                         input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag << FRAC_BITS) / den;
        return clamp_speed((num < 0) ? -quo : quo);
    endfunction

    // picks the targets for one tick, advances the failsafe state, mixes the wheels
    function automatic t_wheel_cmd mix_tick(input t_rc_tick t);
        t_wheel_cmd                           c;
        logic signed [rcddm_pkg::SPEED_W-1:0] lin;
        logic signed [rcddm_pkg::SPEED_W-1:0] ang;
        rcddm_pkg::t_drive_mode               mode;
        longint                               half;
        longint                               lin_div;
        longint                               ang_div;
        longint                               thr_ctr;
        longint                               roll_ctr;
        lin_div  = longint'(rcddm_pkg::SCALE_ODD_DIV) << rcddm_pkg::LIN_DIV_LOG2;
        ang_div  = longint'(rcddm_pkg::SCALE_ODD_DIV) << rcddm_pkg::ANG_DIV_LOG2;
        thr_ctr  = longint'(rcddm_pkg::THR_CENTER);
        roll_ctr = longint'(rcddm_pkg::ROLL_CENTER);
        if (!t.frame) begin
            if (missed_cnt < cur_failsafe) begin
                // frame lost, still within tolerance: keep the last targets
                missed_cnt = missed_cnt + 1'b1;
                lin  = last_lin;
                ang  = last_ang;
                mode = rcddm_pkg::MODE_HOLD;
            end else begin
                // tolerance used up, or lowered below the count: uplink takes over
                lin  = t.up_lin;
                ang  = t.up_ang;
                mode = rcddm_pkg::MODE_UPLINK;
            end
        end else begin
            missed_cnt = '0;
            if (t.mode_ch < rcddm_pkg::MODE_STOP_LIM) begin
                lin  = '0;
                ang  = '0;
                mode = rcddm_pkg::MODE_STOP;
            end else if (t.mode_ch < rcddm_pkg::MODE_RC_LIM) begin
                lin  = t.up_lin;
                ang  = t.up_ang;
                mode = rcddm_pkg::MODE_UPLINK;
            end else begin
                mode = rcddm_pkg::MODE_RC;
                if (t.pitch > rcddm_pkg::PITCH_FWD_LIM) begin
                    lin = stick_speed(thr_ctr - longint'(t.thr), lin_div);
                end else if (t.pitch > rcddm_pkg::PITCH_BWD_LIM) begin
                    lin = '0;
                end else begin
                    lin = stick_speed(longint'(t.thr) - thr_ctr, lin_div);
                end
                if (t.roll > rcddm_pkg::ROLL_HIGH_LIM || t.roll < rcddm_pkg::ROLL_LOW_LIM) begin
                    ang = stick_speed(roll_ctr - longint'(t.roll), ang_div);
                end else begin
                    ang = '0;
                end
            end
        end
        last_lin = lin;
        last_ang = ang;
        half = (longint'(ang) * longint'(cur_track)) / (longint'(1) << rcddm_pkg::MIX_SHIFT);
        c.left_spd  = clamp_speed(longint'(lin) - half);
        c.right_spd = clamp_speed(longint'(lin) + half);
        c.lin       = lin;
        c.ang       = ang;
        c.mode      = mode;
        return c;
    endfunction

    function automatic t_rc_tick mk_tick(input logic frame, input int roll, input int thr,
                                         input int pitch, input int mode_ch,
                                         input int up_lin, input int up_ang);
        t_rc_tick t;
        t.frame   = frame;
        t.roll    = rcddm_pkg::CH_W'(roll);
        t.thr     = rcddm_pkg::CH_W'(thr);
        t.pitch   = rcddm_pkg::CH_W'(pitch);
        t.mode_ch = rcddm_pkg::CH_W'(mode_ch);
        t.up_lin  = rcddm_pkg::SPEED_W'(up_lin);
        t.up_ang  = rcddm_pkg::SPEED_W'(up_ang);
        return t;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one step either side of a band edge or a stick center
    function automatic logic [rcddm_pkg::CH_W-1:0] near_limit();
        logic [rcddm_pkg::CH_W-1:0] base;
        case ($urandom_range(0, 5))
            0:       base = rcddm_pkg::MODE_STOP_LIM;
            1:       base = rcddm_pkg::MODE_RC_LIM;
            2:       base = rcddm_pkg::ROLL_LOW_LIM;
            3:       base = rcddm_pkg::ROLL_HIGH_LIM;
            4:       base = rcddm_pkg::THR_CENTER[rcddm_pkg::CH_W-1:0];
            default: base = rcddm_pkg::ROLL_CENTER[rcddm_pkg::CH_W-1:0];
        endcase
        return base + rcddm_pkg::CH_W'($urandom_range(0, 2)) - 1'b1;
    endfunction

    function automatic logic [rcddm_pkg::CH_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0, 1:    return near_limit();
            2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            3, 4:    return rcddm_pkg::CH_W'($urandom_range(0, 2047));
            default: return rcddm_pkg::CH_W'($urandom_range(172, 2047));  // usual stick travel
        endcase
    endfunction

    // weighted toward rc mode so the stick scaling gets most of the traffic
    function automatic logic [rcddm_pkg::CH_W-1:0] rand_mode_ch();
        case ($urandom_range(0, 19))
            0, 1, 2:       return rcddm_pkg::CH_W'($urandom_range(0, 599));
            3, 4, 5, 6:    return rcddm_pkg::CH_W'($urandom_range(600, 1399));
            7, 8, 9:       return near_limit();
            default:       return rcddm_pkg::CH_W'($urandom_range(1400, 2047));
        endcase
    endfunction

    function automatic logic signed [rcddm_pkg::SPEED_W-1:0] rand_speed();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return rcddm_pkg::SPEED_W'($urandom);
        endcase
    endfunction

    function automatic t_rc_tick rand_tick(input logic frame);
        t_rc_tick t;
        t.frame   = frame;
        t.roll    = rand_channel();
        t.thr     = rand_channel();
        t.pitch   = rand_channel();
        t.mode_ch = rand_mode_ch();
        t.up_lin  = rand_speed();
        t.up_ang  = rand_speed();
        return t;
    endfunction

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // offers one word, holds it through any stall, books the expected command
    task automatic send_tick(input t_rc_tick t);
        int gap;
        i_in_valid         <= 1'b1;
        i_frame_valid      <= t.frame;
        i_roll_channel     <= t.roll;
        i_throttle_channel <= t.thr;
        i_pitch_channel    <= t.pitch;
        i_mode_channel     <= t.mode_ch;
        i_uplink_linear    <= t.up_lin;
        i_uplink_angular   <= t.up_ang;
        do @(posedge i_clk); while (o_in_stall);
        cmd_q.push_back(mix_tick(t));
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // valid drops after each accepted write so back-to-back writes never collide
    task automatic write_reg(input logic [rcddm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcddm_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rcddm_pkg::REG_TRACK_WIDTH:    cur_track    = val[rcddm_pkg::TRACK_W-1:0];
            rcddm_pkg::REG_FAILSAFE_TICKS: cur_failsafe = val[rcddm_pkg::TICKS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // junk in the upper data bits must not reach the tick limit
    task automatic write_failsafe(input logic [rcddm_pkg::TICKS_W-1:0] ticks);
        write_reg(rcddm_pkg::REG_FAILSAFE_TICKS, {8'($urandom), ticks});
    endtask

    // stop offering and wait until every booked command has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode and pitch band edges, roll dead zone edges, field extremes, reset config
    task automatic test_bands();
        send_tick(mk_tick(1'b1, 1000, 1000, 1000,    0,  32767, -32768));  // stop
        send_tick(mk_tick(1'b1, 2047, 2047, 2047,  599, -32768,  32767));  // top of stop band
        send_tick(mk_tick(1'b1,    0,    0,    0,  600,  32767,  32767));  // uplink from 600
        send_tick(mk_tick(1'b1,    0,    0,    0, 1399, -32768, -32768));  // top of uplink band
        send_tick(mk_tick(1'b1,    0,    0, 1401, 1400,      0,      0));  // rc forward, full roll
        send_tick(mk_tick(1'b1,  699, 2047, 1400, 2047,  12345, -12345));  // dead zone upper edge
        send_tick(mk_tick(1'b1,  700, 1500,  601, 1800,      1,     -1));  // roll dead zone low edge
        send_tick(mk_tick(1'b1, 1300, 2047,  600, 1500,     -1,      1));  // backward, roll edge
        send_tick(mk_tick(1'b1, 1301,    0,    0, 1600,  21845, -21846));  // full backward
        send_tick(mk_tick(1'b1, 2047, 2001, 2047, 2047, -21846,  21845));  // throttle past center
        settle();
    endtask

    // held targets through the reset tolerance, then uplink fallback, then recovery
    task automatic test_failsafe_hold();
        send_tick(mk_tick(1'b1, 200, 1700, 1900, 1900, 4096, -4096));
        repeat (int'(rcddm_pkg::FAILSAFE_RESET) + 1) send_tick(rand_tick(1'b0));
        send_tick(mk_tick(1'b1, 1000, 1000, 1000, 1000, -300, 300));
        settle();
    endtask

    // receiver holds off long while the sender keeps pushing: the block fills and stalls
    task automatic test_backpressure();
        no_idle      = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) send_tick(rand_tick($urandom_range(0, 4) != 0));
        settle();
        no_idle = 1'b0;
    endtask

    // config sweeps with mostly framed ticks and bursts of lost frames
    task automatic test_random();
        int burst;
        int sent;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // tick limit goes 15 -> 0 -> 1 so a lowered limit meets a high count
            case (ph)
                0: begin
                    write_reg(rcddm_pkg::REG_TRACK_WIDTH, 12'd4095);
                    write_failsafe(4'd15);
                end
                1: begin
                    write_reg(rcddm_pkg::REG_TRACK_WIDTH, 12'd0);
                    write_failsafe(4'd0);
                end
                2: begin
                    write_reg(rcddm_pkg::REG_TRACK_WIDTH, 12'd1);
                    write_failsafe(4'd1);
                end
                4: begin
                    write_reg(REG_SPARE_A, rcddm_pkg::CFG_DATA_W'($urandom));
                    write_reg(REG_SPARE_B, rcddm_pkg::CFG_DATA_W'($urandom));
                    write_reg(rcddm_pkg::REG_TRACK_WIDTH, rcddm_pkg::CFG_DATA_W'($urandom));
                    write_failsafe(rcddm_pkg::TICKS_W'($urandom));
                end
                default: begin
                    write_reg(rcddm_pkg::REG_TRACK_WIDTH, rcddm_pkg::CFG_DATA_W'($urandom));
                    write_failsafe(rcddm_pkg::TICKS_W'($urandom));
                end
            endcase
            no_idle = (ph == 3);
            // open on lost frames so the count left by the last phase is seen
            repeat ($urandom_range(1, 4)) send_tick(rand_tick(1'b0));
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if ($urandom_range(0, 7) == 0) begin
                    burst = $urandom_range(1, int'(cur_failsafe) + 3);
                    repeat (burst) send_tick(rand_tick(1'b0));
                    sent += burst;
                end else begin
                    send_tick(rand_tick(1'b1));
                    sent++;
                end
            end
            // run the count up to the limit before the next setting
            repeat (int'(cur_failsafe) + 1) send_tick(rand_tick(1'b0));
            settle();
        end
        no_idle = 1'b0;
    endtask

    // receiver: random stall runs, one long hold-off on request
    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = idle_len() - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // each accepted result word against the oldest booked command
    always @(posedge i_clk) begin : result_check
        t_wheel_cmd got;
        t_wheel_cmd want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.left_spd  = o_left_speed;
            got.right_spd = o_right_speed;
            got.lin       = o_target_linear;
            got.ang       = o_target_angular;
            got.mode      = rcddm_pkg::t_drive_mode'(o_drive_mode);
            if (cmd_q.size() == 0) begin
                note_fail($sformatf("result word with nothing expected: L=%0d R=%0d mode=%0d",
                                    $signed(got.left_spd), $signed(got.right_spd), got.mode));
            end else begin
                want = cmd_q.pop_front();
                if (got !== want) begin
                    note_fail({$sformatf("mismatch exp L=%0d R=%0d lin=%0d ang=%0d mode=%0d",
                                         $signed(want.left_spd), $signed(want.right_spd),
                                         $signed(want.lin), $signed(want.ang), want.mode),
                               $sformatf(" got L=%0d R=%0d lin=%0d ang=%0d mode=%0d",
                                         $signed(got.left_spd), $signed(got.right_spd),
                                         $signed(got.lin), $signed(got.ang), got.mode)});
                end
            end
        end
    end

    // ends the run when no channel has moved a word for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        cur_track    = rcddm_pkg::TRACK_RESET;
        cur_failsafe = rcddm_pkg::FAILSAFE_RESET;
        missed_cnt   = '0;
        last_lin     = '0;
        last_ang     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bands();
        test_failsafe_hold();
        test_backpressure();
        test_random();
        settle();

        if (cmd_q.size() != 0) begin
            note_fail($sformatf("%0d expected words never arrived", cmd_q.size()));
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
